### design/grid_raycast_column_renderer_unit_macros.svh
// Assertion macros for the grid raycast column renderer.
// Used by the top level; the macros expect aclk and aresetn in scope.
`ifndef GRID_RAYCAST_COLUMN_RENDERER_UNIT_MACROS_SVH
`define GRID_RAYCAST_COLUMN_RENDERER_UNIT_MACROS_SVH

// Same-cycle implication check
`define GCR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("gcr check failed");

// Next-cycle implication check
`define GCR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("gcr check failed");

`endif

### design/gcr_pkg.sv
// Shared types, codes and the quarter-wave sine function for the column renderer.
// No dependencies.
package gcr_pkg;

    // Input command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_CAST = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_FOV  = 2'd0;
    localparam logic [1:0] REG_STEP = 2'd1;
    localparam logic [1:0] REG_VIEW = 2'd2;

    // Glyph codes
    localparam logic [3:0] GLYPH_BLANK = 4'd0;
    localparam logic [3:0] GLYPH_SHADE1 = 4'd1;
    localparam logic [3:0] GLYPH_SHADE2 = 4'd2;
    localparam logic [3:0] GLYPH_SHADE3 = 4'd3;
    localparam logic [3:0] GLYPH_SHADE4 = 4'd4;
    localparam logic [3:0] GLYPH_HASH  = 4'd5;
    localparam logic [3:0] GLYPH_X     = 4'd6;
    localparam logic [3:0] GLYPH_TILDE = 4'd7;
    localparam logic [3:0] GLYPH_DASH  = 4'd8;

    typedef struct packed {
        logic        command;
        logic [3:0]  map_row_index;
        logic [15:0] map_row_bits;
        logic [6:0]  column;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [9:0]  view_angle;
    } in_item_t;

    typedef struct packed {
        logic [5:0]  row;
        logic [3:0]  glyph;
        logic [12:0] wall_distance;
        logic        hit;
        logic        last;
    } out_item_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ANG_MUL,
        ST_ANG_SUB,
        ST_DIV,
        ST_ANG,
        ST_SIN,
        ST_COS,
        ST_DIR,
        ST_LOOP,
        ST_STEP,
        ST_MULX,
        ST_MULY,
        ST_READ,
        ST_TEST,
        ST_SHADE,
        ST_EMIT
    } gcr_state_t;

    // Quarter-wave sine in Q14 from a Q30 angle in radians (elaboration only)
    function automatic logic [14:0] quarter_sine(input logic [63:0] z);
        logic [63:0] one;
        logic [63:0] z2;
        logic [63:0] t;
        logic [63:0] r;
        one = 64'd1 << 30;
        z2 = (z * z) >> 30;
        t = one - z2 / 64'd72;
        t = one - ((z2 * t) >> 30) / 64'd42;
        t = one - ((z2 * t) >> 30) / 64'd20;
        t = one - ((z2 * t) >> 30) / 64'd6;
        r = (((z * t) >> 30) + 64'd32768) >> 16;
        return r[14:0];
    endfunction

endpackage

### design/gcr_div.sv
// Divide by a constant through a reciprocal multiply, result registered.
// No package dependency; the caller sets the operand width and the divisor.
module gcr_div #(
    parameter int IN_W    = 20,
    parameter int DIVISOR = 240
) (
    input  logic            aclk,
    input  logic [IN_W-1:0] dividend,
    output logic [IN_W-1:0] quotient
);

    // Rounded-up reciprocal; exact floor for every IN_W-bit dividend
    localparam int SHIFT = IN_W + $clog2(DIVISOR);
    localparam logic [IN_W:0] RECIP =
        (IN_W+1)'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic [2*IN_W+1:0] prod;
    logic [IN_W-1:0]   quo_reg;

    assign prod = (2*IN_W+2)'(dividend) * (2*IN_W+2)'(RECIP);

    always_ff @(posedge aclk) begin
        quo_reg <= IN_W'(prod >> SHIFT);
    end

    assign quotient = quo_reg;

endmodule

### design/gcr_sine_rom.sv
// Quarter-wave sine ROM in Q14 with registered read data.
// Depends on gcr_pkg for the table function.
module gcr_sine_rom #(
    parameter int ANGLE_STEPS = 1024
) (
    input  logic                                aclk,
    input  logic [$clog2(ANGLE_STEPS/4+1)-1:0]  addr,
    output logic [14:0]                         data
);
    import gcr_pkg::*;

    localparam int QUARTER = ANGLE_STEPS / 4;

    logic [14:0] rom [QUARTER+1];
    logic [14:0] data_reg;

    // Table contents worked out at elaboration
    for (genvar i = 0; i <= QUARTER; i++) begin : g_tab
        localparam logic [63:0] ZQ30 = (64'(i) * 64'd1686629713) / 64'(QUARTER);
        assign rom[i] = quarter_sine(ZQ30);
    end

    always_ff @(posedge aclk) begin
        data_reg <= rom[addr];
    end

    assign data = data_reg;

endmodule

### design/gcr_map_mem.sv
// Wall bitmap memory: one write port, one registered read port, per-row valid bits.
// Depends on gcr_pkg.
module gcr_map_mem #(
    parameter int MAP_SIZE = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        wr_en,
    input  logic [$clog2(MAP_SIZE)-1:0] wr_addr,
    input  logic [15:0]                 wr_data,
    input  logic [$clog2(MAP_SIZE)-1:0] rd_addr,
    output logic [15:0]                 rd_data
);
    import gcr_pkg::*;

    logic [15:0]         mem [MAP_SIZE];
    logic [MAP_SIZE-1:0] vld_reg;
    logic [15:0]         rd_reg;
    logic                rd_vld_reg;

    // Storage and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
    end

    // Row valid bits, cleared at reset so unwritten rows read as empty
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? rd_reg : 16'd0;

endmodule

### design/grid_raycast_column_renderer_unit.sv
// Channel   Ports                               Moves
// input     s_valid s_ready s_data              load row or cast column command
// result    m_valid m_ready m_data              one glyph per screen row
// config    cfg_valid cfg_ready cfg_index/data  register write
//
// A load is written on the accept; the renderer stays idle. A cast runs setup after
// the accept (angle sum, a reciprocal multiply for the divide by 2*SCREEN_COLS,
// sine/cosine ROM reads), then march steps through STEP, MULX, MULY, READ and TEST
// (TEST is skipped on a step that leaves the map), then closes the march and picks
// the shade, then emits one glyph per screen row. The march loop runs through one
// shared multiplier and the map memory port. Reset is synchronous (aresetn low); the
// map reads empty. A stall on m_ready holds the sequencer in the output phase.
// Top level of the grid raycast column renderer; uses gcr_pkg, gcr_div,
// gcr_sine_rom, gcr_map_mem and the assertion macro header.
`include "grid_raycast_column_renderer_unit_macros.svh"

module grid_raycast_column_renderer_unit #(
    parameter int MAP_SIZE    = 16,
    parameter int SCREEN_COLS = 120,
    parameter int SCREEN_ROWS = 40,
    parameter int ANGLE_STEPS = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  gcr_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output gcr_pkg::out_item_t m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [12:0]        cfg_data
);
    import gcr_pkg::*;

    localparam int MAW     = $clog2(MAP_SIZE);
    localparam int AAW     = $clog2(ANGLE_STEPS);
    localparam int QUARTER = ANGLE_STEPS / 4;
    localparam int RAW     = $clog2(QUARTER + 1);
    localparam int MAP_LIM = MAP_SIZE * 256;
    localparam int H       = SCREEN_ROWS;
    // Largest angle sum: top view angle, top column and top field of view
    localparam int ACC_MAX = 1023 * 2 * SCREEN_COLS + 2 * 127 * 1023
                           + 2 * ANGLE_STEPS * SCREEN_COLS;
    localparam int ACC_W   = $clog2(ACC_MAX + 1);

    // Configuration registers
    logic [9:0]  fov_reg;
    logic [7:0]  step_reg;
    logic [12:0] vd_reg;

    // Sequencer and datapath registers
    gcr_state_t         state_reg, state_next;
    in_item_t           item_reg, item_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [AAW-1:0]     ang_reg, ang_next;
    logic               neg_reg, neg_next;
    logic signed [15:0] dx_reg, dx_next;
    logic signed [15:0] dy_reg, dy_next;
    logic [12:0]        d_reg, d_next;
    logic               hit_reg, hit_next;
    logic signed [15:0] px_reg, px_next;
    logic signed [15:0] py_reg, py_next;
    logic [3:0]         shade_reg, shade_next;
    logic [21:0]        hd_reg, hd_next;
    logic [21:0]        lhs_reg, lhs_next;
    logic [5:0]         y_reg, y_next;
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_data_reg, m_data_next;

    // Shared units
    logic [ACC_W-1:0]   div_quo;
    logic [RAW-1:0]     rom_addr;
    logic [14:0]        rom_data;
    logic               map_wr;
    logic [MAW-1:0]     map_waddr, map_raddr;
    logic [15:0]        map_rdata;

    // Combinational helpers
    logic               s_fire;
    logic               out_free;
    logic [7:0]         step_eff;
    logic [13:0]        d_sum;
    logic signed [15:0] mul_dir;
    logic signed [29:0] mul_prod;
    logic signed [15:0] mul_pos;
    logic [AAW:0]       rom_ang;
    logic [31:0]        idx_ext;
    logic [15:0]        px_u, py_u;
    logic               out_of_map;
    logic [6:0]         k_val;
    logic [3:0]         floor_glyph;
    logic [3:0]         row_glyph;
    logic [15:0]        rd_pos;

    gcr_div #(.IN_W(ACC_W), .DIVISOR(2 * SCREEN_COLS)) u_div (
        .aclk     (aclk),
        .dividend (acc_reg),
        .quotient (div_quo)
    );

    gcr_sine_rom #(.ANGLE_STEPS(ANGLE_STEPS)) u_rom (
        .aclk (aclk),
        .addr (rom_addr),
        .data (rom_data)
    );

    gcr_map_mem #(.MAP_SIZE(MAP_SIZE)) u_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (map_wr),
        .wr_addr (map_waddr),
        .wr_data (s_data.map_row_bits),
        .rd_addr (map_raddr),
        .rd_data (map_rdata)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    // Map write on a load transaction; out-of-range rows are dropped
    assign idx_ext   = 32'(s_data.map_row_index);
    assign map_wr    = s_fire && (s_data.command == CMD_LOAD) && (idx_ext < 32'(MAP_SIZE));
    assign map_waddr = idx_ext[MAW-1:0];

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fov_reg  <= 10'd128;
            step_reg <= 8'd26;
            vd_reg   <= 13'd4096;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FOV:  fov_reg  <= cfg_data[9:0];
                REG_STEP: step_reg <= cfg_data[7:0];
                REG_VIEW: vd_reg   <= cfg_data;
                default:  ;
            endcase
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_data.command == CMD_CAST) state_next = ST_ANG_MUL;
            end
            ST_ANG_MUL:   state_next = ST_ANG_SUB;
            ST_ANG_SUB:   state_next = ST_DIV;
            ST_DIV:       state_next = ST_ANG;
            ST_ANG:       state_next = ST_SIN;
            ST_SIN:       state_next = ST_COS;
            ST_COS:       state_next = ST_DIR;
            ST_DIR:       state_next = ST_LOOP;
            ST_LOOP:      state_next = (!hit_reg && d_reg < vd_reg) ? ST_STEP : ST_SHADE;
            ST_STEP:      state_next = ST_MULX;
            ST_MULX:      state_next = ST_MULY;
            ST_MULY:      state_next = ST_READ;
            ST_READ:      state_next = out_of_map ? ST_LOOP : ST_TEST;
            ST_TEST:      state_next = ST_LOOP;
            ST_SHADE:     state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_free && y_reg == 6'(H - 1)) state_next = ST_IDLE;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Shared helpers
    assign step_eff = (step_reg == 8'd0) ? 8'd1 : step_reg;
    assign d_sum    = {1'b0, d_reg} + 14'(step_eff);
    assign mul_dir  = (state_reg == ST_MULX) ? dx_reg : dy_reg;
    assign mul_pos  = (state_reg == ST_MULX) ? 16'(item_reg.pos_x) : 16'(item_reg.pos_y);
    assign mul_prod = mul_dir * $signed({1'b0, d_reg});
    assign px_u     = px_reg;
    assign py_u     = py_reg;
    assign out_of_map = px_reg[15] || py_reg[15]
                     || (px_reg >= 16'(MAP_LIM)) || (py_reg >= 16'(MAP_LIM));
    assign map_raddr = py_u[8 +: MAW];
    assign rd_pos    = map_rdata >> px_u[11:8];

    // Floor gradient depends on the row only
    always_comb begin
        k_val = 7'(H) - {1'b0, y_reg};
        if ((10'(k_val) << 3) < 10'(H))                 floor_glyph = GLYPH_HASH;
        else if ((10'(k_val) << 2) < 10'(H))            floor_glyph = GLYPH_X;
        else if ((10'(k_val) << 3) < 10'(3 * H))        floor_glyph = GLYPH_TILDE;
        else if ((11'(k_val) * 11'd20) < 11'(9 * H))    floor_glyph = GLYPH_DASH;
        else                                            floor_glyph = GLYPH_BLANK;
        if (lhs_reg + 22'(512 * H) <= hd_reg)           row_glyph = GLYPH_BLANK;
        else if (lhs_reg <= hd_reg + 22'(512 * H))      row_glyph = shade_reg;
        else                                            row_glyph = floor_glyph;
    end

    // Sine/cosine quadrant folding for the ROM address
    always_comb begin
        if (state_reg == ST_SIN) begin
            rom_ang = {1'b0, ang_reg};
        end else begin
            rom_ang = {1'b0, ang_reg} + (AAW+1)'(QUARTER);
            if (rom_ang >= (AAW+1)'(ANGLE_STEPS)) rom_ang = rom_ang - (AAW+1)'(ANGLE_STEPS);
        end
        if (rom_ang < (AAW+1)'(QUARTER)) begin
            rom_addr = RAW'(rom_ang);
            neg_next = 1'b0;
        end else if (rom_ang < (AAW+1)'(2 * QUARTER)) begin
            rom_addr = RAW'((AAW+1)'(2 * QUARTER) - rom_ang);
            neg_next = 1'b0;
        end else if (rom_ang < (AAW+1)'(3 * QUARTER)) begin
            rom_addr = RAW'(rom_ang - (AAW+1)'(2 * QUARTER));
            neg_next = 1'b1;
        end else begin
            rom_addr = RAW'((AAW+1)'(4 * QUARTER) - rom_ang);
            neg_next = 1'b1;
        end
    end

    // Datapath updates per state
    always_comb begin
        item_next    = item_reg;
        acc_next     = acc_reg;
        ang_next     = ang_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        d_next       = d_reg;
        hit_next     = hit_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        shade_next   = shade_reg;
        hd_next      = hd_reg;
        lhs_next     = lhs_reg;
        y_next       = y_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_ready ? 1'b0 : m_valid_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    item_next = s_data;
                    acc_next  = ACC_W'(s_data.view_angle) * ACC_W'(2 * SCREEN_COLS)
                              + ACC_W'(2 * ANGLE_STEPS * SCREEN_COLS);
                end
            end
            ST_ANG_MUL: acc_next = acc_reg + (ACC_W'(item_reg.column) * ACC_W'(fov_reg) << 1);
            ST_ANG_SUB: acc_next = acc_reg - ACC_W'(fov_reg) * ACC_W'(SCREEN_COLS);
            // Quotient wraps on the angle circle by keeping its low bits
            ST_ANG: ang_next = div_quo[AAW-1:0];
            ST_COS: dx_next = neg_reg ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});
            ST_DIR: begin
                dy_next  = neg_reg ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});
                d_next   = '0;
                hit_next = 1'b0;
                px_next  = 16'(item_reg.pos_x);
                py_next  = 16'(item_reg.pos_y);
            end
            ST_STEP: d_next = (d_sum > 14'(vd_reg)) ? vd_reg : d_sum[12:0];
            ST_MULX: px_next = mul_pos + mul_prod[29:14];
            ST_MULY: py_next = mul_pos + mul_prod[29:14];
            ST_READ: begin
                if (out_of_map) begin
                    hit_next = 1'b1;
                    d_next   = vd_reg;
                end
            end
            ST_TEST: if (px_u[15:8] < 8'd16 && rd_pos[0]) hit_next = 1'b1;
            ST_SHADE: begin
                if ((15'(d_reg) << 2) <= 15'(vd_reg))        shade_next = GLYPH_SHADE1;
                else if (15'(d_reg) * 15'd3 < 15'(vd_reg))   shade_next = GLYPH_SHADE2;
                else if ((15'(d_reg) << 1) < 15'(vd_reg))    shade_next = GLYPH_SHADE3;
                else if (d_reg < vd_reg)                     shade_next = GLYPH_SHADE4;
                else                                         shade_next = GLYPH_BLANK;
                hd_next  = 22'(d_reg) * 22'(H);
                lhs_next = '0;
                y_next   = '0;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next              = 1'b1;
                    m_data_next.row           = y_reg;
                    m_data_next.glyph         = row_glyph;
                    m_data_next.wall_distance = d_reg;
                    m_data_next.hit           = hit_reg;
                    m_data_next.last          = (y_reg == 6'(H - 1));
                    y_next                    = y_reg + 6'd1;
                    lhs_next                  = lhs_reg + (22'(d_reg) << 1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        item_reg   <= item_next;
        acc_reg    <= acc_next;
        ang_reg    <= ang_next;
        neg_reg    <= (state_reg == ST_SIN || state_reg == ST_COS) ? neg_next : neg_reg;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        d_reg      <= d_next;
        hit_reg    <= hit_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        shade_reg  <= shade_next;
        hd_reg     <= hd_next;
        lhs_reg    <= lhs_next;
        y_reg      <= y_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Checks on sequencer and datapath
    `GCR_ASSERT_NOW(a_last_row, m_valid && m_data.last, m_data.row == 6'(H - 1))
    `GCR_ASSERT_NOW(a_dist_cap, state_reg == ST_LOOP, d_reg <= vd_reg)
    `GCR_ASSERT_NEXT(a_emit_valid, state_reg == ST_EMIT && out_free, m_valid)

endmodule

### test/grid_raycast_column_renderer_checker.sv
// Checker for the grid raycast column renderer: watches the config, command and
// glyph channels, predicts each column's glyphs and compares them in order.
// Depends on gcr_pkg for the payload structs, register indexes and glyph codes.
module grid_raycast_column_renderer_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  gcr_pkg::in_item_t  s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  gcr_pkg::out_item_t m_data,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [12:0]        cfg_data,
    output int                 mismatch_count,
    output int                 glyphs_pending,
    output int                 columns_cast,
    output int                 glyphs_checked
);
    import gcr_pkg::*;

    localparam int ROWS = 40;

    logic [15:0] walls [16];
    logic [9:0]  fov;
    logic [7:0]  step_len;
    logic [12:0] view_dist;
    out_item_t   glyph_q [$];

    // Quarter-wave sine, Q14 result from an angle index in [0, 256]
    function automatic longint quarter_wave(longint unsigned x);
        longint unsigned z, z2, t, one;
        one = 64'd1 << 30;
        z   = (x * 64'd1686629713) / 64'd256;
        z2  = (z * z) >> 30;
        t   = one - z2 / 64'd72;
        t   = one - ((z2 * t) >> 30) / 64'd42;
        t   = one - ((z2 * t) >> 30) / 64'd20;
        t   = one - ((z2 * t) >> 30) / 64'd6;
        return longint'((((z * t) >> 30) + 64'd32768) >> 16);
    endfunction

    function automatic longint sine_q14(longint unsigned a);
        a = a % 1024;
        if (a < 256) return quarter_wave(a);
        if (a < 512) return quarter_wave(512 - a);
        if (a < 768) return -quarter_wave(a - 512);
        return -quarter_wave(1024 - a);
    endfunction

    // Whole cast: angle, march, shade, then one glyph per screen row
    task automatic predict_column(in_item_t cmd);
        longint unsigned total, ang;
        longint dx, dy, px, py, px0, py0, d, vd, stp, lhs, hd, k;
        logic hit;
        logic [3:0] shade, g;
        out_item_t e;
        total = longint'(cmd.view_angle) * 240 + 2 * longint'(cmd.column) * fov
              + 2 * 1024 * 120 - longint'(fov) * 120;
        ang = (total / 240) % 1024;
        dx  = sine_q14(ang);
        dy  = sine_q14(ang + 256);
        vd  = view_dist;
        stp = (step_len == 0) ? 1 : step_len;
        px0 = cmd.pos_x;
        py0 = cmd.pos_y;
        d   = 0;
        hit = 1'b0;
        while (!hit && d < vd) begin
            d  = (d + stp > vd) ? vd : d + stp;
            px = px0 + ((dx * d) >>> 14);
            py = py0 + ((dy * d) >>> 14);
            if (px < 0 || py < 0 || px >= 4096 || py >= 4096) begin
                hit = 1'b1;
                d   = vd;
            end else if (walls[py[11:8]][px[11:8]]) begin
                hit = 1'b1;
            end
        end
        if (4 * d <= vd)      shade = GLYPH_SHADE1;
        else if (3 * d < vd)  shade = GLYPH_SHADE2;
        else if (2 * d < vd)  shade = GLYPH_SHADE3;
        else if (d < vd)      shade = GLYPH_SHADE4;
        else                  shade = GLYPH_BLANK;
        for (int y = 0; y < ROWS; y++) begin
            lhs = 2 * y * d;
            hd  = ROWS * d;
            k   = ROWS - y;
            if (lhs + 512 * ROWS <= hd)     g = GLYPH_BLANK;
            else if (lhs <= hd + 512 * ROWS) g = shade;
            else if (8 * k < ROWS)          g = GLYPH_HASH;
            else if (4 * k < ROWS)          g = GLYPH_X;
            else if (8 * k < 3 * ROWS)      g = GLYPH_TILDE;
            else if (20 * k < 9 * ROWS)     g = GLYPH_DASH;
            else                            g = GLYPH_BLANK;
            e.row           = 6'(y);
            e.glyph         = g;
            e.wall_distance = d[12:0];
            e.hit           = hit;
            e.last          = (y == ROWS - 1);
            glyph_q.push_back(e);
        end
    endtask

    task automatic report_field(string fname, longint exp_v, longint act_v);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, exp_v, act_v);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        out_item_t e;
        if (!aresetn) begin
            foreach (walls[i]) walls[i] = '0;
            fov            = 10'd128;
            step_len       = 8'd26;
            view_dist      = 13'd4096;
            glyph_q.delete();
            mismatch_count = 0;
            columns_cast   = 0;
            glyphs_checked = 0;
        end else begin
            // Result side first: compare with the oldest expected glyph
            if (m_valid && m_ready) begin
                glyphs_checked++;
                if (glyph_q.size() == 0) begin
                    $display("%0t: unexpected glyph transaction, actual %p", $time, m_data);
                    mismatch_count++;
                end else begin
                    e = glyph_q.pop_front();
                    if (e.row != m_data.row) report_field("row", e.row, m_data.row);
                    if (e.glyph != m_data.glyph)
                        report_field("glyph", e.glyph, m_data.glyph);
                    if (e.wall_distance != m_data.wall_distance)
                        report_field("wall_distance", e.wall_distance, m_data.wall_distance);
                    if (e.hit != m_data.hit) report_field("hit", e.hit, m_data.hit);
                    if (e.last != m_data.last) report_field("last", e.last, m_data.last);
                end
            end
            // Register writes; index 3 is ignored
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_FOV:  fov       = cfg_data[9:0];
                    REG_STEP: step_len  = cfg_data[7:0];
                    REG_VIEW: view_dist = cfg_data;
                    default: ;
                endcase
            end
            // Command side
            if (s_valid && s_ready) begin
                if (s_data.command == CMD_LOAD) begin
                    walls[s_data.map_row_index] = s_data.map_row_bits;
                end else begin
                    predict_column(s_data);
                    columns_cast++;
                end
            end
        end
        glyphs_pending = glyph_q.size();
    end

endmodule

### test/testbench.sv
// Top of the column renderer testbench: clock, reset, config and command stimulus,
// receiver stalls, watchdog and verdict. Depends on gcr_pkg, the renderer RTL and
// grid_raycast_column_renderer_checker.
module testbench;
    import gcr_pkg::*;

    localparam logic [1:0] REG_SPARE   = 2'd3;
    localparam int         IDLE_LIMIT  = 200000;
    localparam int         DRAIN_WAIT  = 200;
    localparam int         IN_W        = $bits(in_item_t);

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_item_t   s_data;
    logic       m_valid;
    logic       m_ready;
    out_item_t  m_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [12:0] cfg_data;

    int mismatch_count, glyphs_pending, columns_cast, glyphs_checked;
    int burst_left;
    int idle_cycles;
    bit backpressure_go;
    bit backpressure_done;

    grid_raycast_column_renderer_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    grid_raycast_column_renderer_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .mismatch_count(mismatch_count), .glyphs_pending(glyphs_pending),
        .columns_cast(columns_cast), .glyphs_checked(glyphs_checked)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // Register write, only issued while the renderer is idle
    task automatic write_reg(logic [1:0] idx, logic [12:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Wait for all glyphs, then let a trailing load settle
    task automatic drain();
        wait (glyphs_pending == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // Offer one command; bursts with random gaps between them
    task automatic send_cmd(in_item_t item);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 20)) @(negedge aclk);
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_valid = 1'b1;
        s_data  = item;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        s_valid = 1'b0;
        s_data  = IN_W'({$urandom, $urandom});
    endtask

    task automatic load_row(logic [3:0] idx, logic [15:0] bits);
        in_item_t it;
        it = IN_W'({$urandom, $urandom});
        it.command       = CMD_LOAD;
        it.map_row_index = idx;
        it.map_row_bits  = bits;
        send_cmd(it);
    endtask

    task automatic cast_col(logic [6:0] col, logic [11:0] x, logic [11:0] y, logic [9:0] va);
        in_item_t it;
        it = IN_W'({$urandom, $urandom});
        it.command    = CMD_CAST;
        it.column     = col;
        it.pos_x      = x;
        it.pos_y      = y;
        it.view_angle = va;
        send_cmd(it);
    endtask

    // Receiver: random stall pattern, changing mode, one long hold-off
    initial begin
        int mode_left;
        int hold_left;
        bit choppy;
        m_ready   = 1'b0;
        mode_left = 0;
        hold_left = 0;
        choppy    = 1'b0;
        forever begin
            @(negedge aclk);
            if (backpressure_go && !backpressure_done && hold_left == 0) begin
                hold_left         = 3000;
                backpressure_done = 1'b1;
            end
            if (mode_left == 0) begin
                mode_left = $urandom_range(50, 400);
                choppy    = $urandom_range(0, 2) != 0;
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_ready = 1'b0;
            end else begin
                m_ready = choppy ? ($urandom_range(0, 3) != 0) : 1'b1;
            end
        end
    end

    // Watchdog on cycles with no transaction on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        logic [15:0] bits;
        aresetn           = 1'b0;
        s_valid           = 1'b0;
        s_data            = '0;
        cfg_valid         = 1'b0;
        cfg_index         = REG_FOV;
        cfg_data          = '0;
        burst_left        = 0;
        backpressure_go   = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: empty map first, then walls, edges of every field
        cast_col(7'd0, 12'd0, 12'd0, 10'd0);
        load_row(4'd0, 16'hFFFF);
        load_row(4'd15, 16'hFFFF);
        load_row(4'd5, 16'h8001);
        load_row(4'd10, 16'h5AA5);
        cast_col(7'd0, 12'd0, 12'd0, 10'd0);
        cast_col(7'd127, 12'd4095, 12'd4095, 10'd1023);
        cast_col(7'd119, 12'd2048, 12'd2048, 10'd256);
        cast_col(7'd60, 12'd1408, 12'd1408, 10'd512);   // viewer in an open cell of row 5
        cast_col(7'd1, 12'd2200, 12'd900, 10'd768);
        drain();
        write_reg(REG_FOV, 13'd1023);
        write_reg(REG_STEP, 13'd0);                       // zero step acts as one
        write_reg(REG_VIEW, 13'd300);
        cast_col(7'd0, 12'd2000, 12'd2000, 10'd100);
        cast_col(7'd119, 12'd2000, 12'd2000, 10'd900);
        drain();
        write_reg(REG_VIEW, 13'd0);                       // no march at all
        write_reg(REG_SPARE, 13'h1FFF);                   // ignored index
        cast_col(7'd64, 12'd1000, 12'd3000, 10'd333);
        drain();
        write_reg(REG_FOV, 13'd0);
        write_reg(REG_STEP, 13'd255);
        write_reg(REG_VIEW, 13'h1FFF);
        cast_col(7'd5, 12'd300, 12'd3800, 10'd42);
        cast_col(7'd100, 12'd3800, 12'd300, 10'd700);
        drain();

        // Random phases: well-formed load/cast mixes under varied settings
        for (int phase = 0; phase < 5; phase++) begin
            write_reg(REG_FOV, 13'($urandom_range(0, 1023)));
            write_reg(REG_STEP, 13'((phase == 4) ? 1 : $urandom_range(8, 255)));
            write_reg(REG_VIEW, 13'((phase == 4) ? 256 : $urandom_range(256, 4096)));
            if (phase == 1) backpressure_go = 1'b1;
            for (int n = 0; n < 60; n++) begin
                if ($urandom_range(0, 9) < 3) begin
                    bits = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                      : 16'($urandom & $urandom & $urandom);
                    load_row(4'($urandom), bits);
                end else begin
                    cast_col(7'($urandom), 12'($urandom), 12'($urandom), 10'($urandom));
                end
            end
            drain();
        end

        wait (glyphs_pending == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
        $display("Covered %0d cast columns and %0d glyphs, directed edges plus 5 random",
                 columns_cast, glyphs_checked);
        $display("settings phases, zero step, zero view distance and a long output stall.");
        if (mismatch_count == 0 && glyphs_pending == 0 && backpressure_done) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
